// ===== rtl/core/stt_pkg.sv =====
// ----------------------------------------------------------------------------
// Software timer table package
// Command codes, result kinds and the control/status structs shared by the
// controller, the datapath and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package stt_pkg;

    // Table size default and bounds of a tick report
    localparam int SLOTS_DEF = 16;
    localparam int MAX_FIRES = 16;
    localparam int FCNT_W    = $clog2(MAX_FIRES + 1);

    // Field widths
    localparam int CMD_W  = 2;
    localparam int KIND_W = 3;
    localparam int ID_W   = 32;
    localparam int MS_W   = 32;
    localparam int TAG_W  = 8;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CANCEL = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_ADDED     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FULL      = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CANCELLED = 3'd2;
    localparam logic [KIND_W-1:0] KIND_NOT_FOUND = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FIRED     = 3'd4;
    localparam logic [KIND_W-1:0] KIND_NO_FIRE   = 3'd5;

    // Controller to datapath commands
    typedef struct packed {
        logic load;        // latch the accepted command word
        logic add_write;   // write new entry at the scan index
        logic add_full;    // report table full
        logic rd_en;       // read entry at the scan index
        logic cancel_hit;  // free the entry that matched
        logic not_found;   // report cancel miss
        logic tick_end;    // flush the pending fire or report no fire
    } t_ctl_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic slot_free;   // entry at the scan index is free
        logic match;       // entry just read holds the cancel id
    } t_ctl_sts;

endpackage

`default_nettype wire

// ===== rtl/core/stt_ctrl.sv =====
// ----------------------------------------------------------------------------
// Software timer table controller
// Sequences the slot scan for add, cancel and tick commands.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_ctrl #(
    parameter int SLOTS = stt_pkg::SLOTS_DEF,
    parameter int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic [stt_pkg::CMD_W-1:0] i_cmd,
    input  wire stt_pkg::t_ctl_sts         i_sts,
    output stt_pkg::t_ctl_cmd              o_ctl,
    output logic [IDX_W-1:0]               o_idx
);
    import stt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_CANCEL,
        S_CANCEL_WAIT,
        S_TICK,
        S_TICK_WAIT,
        S_TICK_END
    } t_state;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             last_idx;

    assign last_idx = (r_idx == LAST_IDX);
    assign busy     = (r_state != S_IDLE);
    assign o_idx    = r_idx;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        o_ctl   = '0;
        case (r_state)
            S_IDLE: begin
                n_idx = '0;
                if (start) begin
                    o_ctl.load = 1'b1;
                    case (i_cmd)
                        CMD_ADD:    n_state = S_ADD;
                        CMD_CANCEL: n_state = S_CANCEL;
                        CMD_TICK:   n_state = S_TICK;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_ADD: begin
                if (i_sts.slot_free) begin
                    o_ctl.add_write = 1'b1;
                    n_state = S_IDLE;
                end else if (last_idx) begin
                    o_ctl.add_full = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_CANCEL: begin
                o_ctl.rd_en = 1'b1;
                if (i_sts.match) begin
                    o_ctl.cancel_hit = 1'b1;
                    n_state = S_IDLE;
                end else if (last_idx) begin
                    n_state = S_CANCEL_WAIT;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_CANCEL_WAIT: begin
                if (i_sts.match) begin
                    o_ctl.cancel_hit = 1'b1;
                end else begin
                    o_ctl.not_found = 1'b1;
                end
                n_state = S_IDLE;
            end
            S_TICK: begin
                o_ctl.rd_en = 1'b1;
                if (last_idx) begin
                    n_state = S_TICK_WAIT;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_TICK_WAIT: begin
                n_state = S_TICK_END;
            end
            S_TICK_END: begin
                o_ctl.tick_end = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and scan index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/stt_dp.sv =====
// ----------------------------------------------------------------------------
// Software timer table datapath
// Entry memory, live bits, id counter, tick update and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_dp #(
    parameter int SLOTS = stt_pkg::SLOTS_DEF,
    parameter int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire stt_pkg::t_ctl_cmd          i_ctl,
    input  wire logic [IDX_W-1:0]           i_idx,
    output stt_pkg::t_ctl_sts               o_sts,
    input  wire logic [stt_pkg::CMD_W-1:0]  i_cmd,
    input  wire logic [stt_pkg::MS_W-1:0]   i_interval_ms,
    input  wire logic                       i_one_shot,
    input  wire logic [stt_pkg::ID_W-1:0]   i_cancel_id,
    input  wire logic [stt_pkg::MS_W-1:0]   i_delta_ms,
    input  wire logic [stt_pkg::TAG_W-1:0]  i_frame_tag,
    output logic                            o_valid,
    output logic [stt_pkg::KIND_W-1:0]      o_kind,
    output logic [stt_pkg::ID_W-1:0]        o_task_id,
    output logic                            o_last
);
    import stt_pkg::*;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [MS_W-1:0]  period;
        logic [MS_W-1:0]  remaining;
        logic             one_shot;
        logic [TAG_W-1:0] frame;
    } t_entry;

    // Entry store and live bits
    t_entry           r_mem [SLOTS];
    logic [SLOTS-1:0] r_live;

    // Latched command word
    logic [CMD_W-1:0] r_op;
    logic [MS_W-1:0]  r_interval;
    logic             r_one_shot;
    logic [ID_W-1:0]  r_cid;
    logic [MS_W-1:0]  r_delta;
    logic [TAG_W-1:0] r_tag;
    logic [ID_W-1:0]  r_next_id;

    // Read stage
    t_entry           r_rd_data;
    logic             r_rd_vld;
    logic [IDX_W-1:0] r_rd_idx;

    // Fire reporting
    logic [FCNT_W-1:0] r_fcnt;
    logic              r_pend_vld;
    logic [ID_W-1:0]   r_pend_id;

    // Result register
    logic              r_out_vld, n_out_vld;
    logic [KIND_W-1:0] r_out_kind, n_out_kind;
    logic [ID_W-1:0]   r_out_id, n_out_id;
    logic              r_out_last, n_out_last;

    // Tick update of the entry just read
    logic             rd_live;
    logic             visit;
    logic [MS_W-1:0]  rem_dec;
    logic             fire;
    logic             report;
    t_entry           upd;

    // Write port
    logic             we;
    logic [IDX_W-1:0] wa;
    t_entry           wd;

    assign rd_live = r_live[r_rd_idx];
    assign visit   = r_rd_vld && (r_op == CMD_TICK) && rd_live;
    assign rem_dec = (r_rd_data.remaining > r_delta) ? (r_rd_data.remaining - r_delta) : '0;
    assign fire    = (rem_dec == '0) && (r_rd_data.frame != r_tag);
    assign report  = visit && fire && (r_fcnt < FCNT_W'(MAX_FIRES));

    always_comb begin
        upd           = r_rd_data;
        upd.remaining = (fire && !r_rd_data.one_shot) ? r_rd_data.period : rem_dec;
        upd.frame     = r_tag;
    end

    assign o_sts.slot_free = !r_live[i_idx];
    assign o_sts.match     = r_rd_vld && rd_live && (r_rd_data.id == r_cid);

    // Select the memory write
    always_comb begin
        we = 1'b0;
        wa = i_idx;
        wd = '{id: r_next_id, period: r_interval, remaining: r_interval,
               one_shot: r_one_shot, frame: r_tag};
        if (i_ctl.add_write) begin
            we = 1'b1;
        end else if (visit) begin
            we = 1'b1;
            wa = r_rd_idx;
            wd = upd;
        end
    end

    // Write and read the entry store
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_idx];
        end
        r_rd_idx <= i_idx;
    end

    // Latch the command word
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_op       <= i_cmd;
            r_interval <= i_interval_ms;
            r_one_shot <= i_one_shot;
            r_cid      <= i_cancel_id;
            r_delta    <= i_delta_ms;
            r_tag      <= i_frame_tag;
        end
    end

    // Live bits, id counter, read valid and fire tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live     <= '0;
            r_next_id  <= '0;
            r_rd_vld   <= 1'b0;
            r_fcnt     <= '0;
            r_pend_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_ctl.rd_en;
            if (i_ctl.add_write) begin
                r_live[i_idx] <= 1'b1;
                r_next_id     <= r_next_id + 1'b1;
            end
            if (i_ctl.cancel_hit) begin
                r_live[r_rd_idx] <= 1'b0;
            end
            if (visit && fire && r_rd_data.one_shot) begin
                r_live[r_rd_idx] <= 1'b0;
            end
            if (i_ctl.load) begin
                r_fcnt     <= '0;
                r_pend_vld <= 1'b0;
            end else if (report) begin
                r_fcnt     <= r_fcnt + 1'b1;
                r_pend_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (report) begin
            r_pend_id <= r_rd_data.id;
        end
    end

    // Build the next result word
    always_comb begin
        n_out_vld  = 1'b0;
        n_out_kind = r_out_kind;
        n_out_id   = r_out_id;
        n_out_last = r_out_last;
        if (i_ctl.add_write) begin
            n_out_vld  = 1'b1;
            n_out_kind = KIND_ADDED;
            n_out_id   = r_next_id;
            n_out_last = 1'b1;
        end else if (i_ctl.add_full) begin
            n_out_vld  = 1'b1;
            n_out_kind = KIND_FULL;
            n_out_id   = '0;
            n_out_last = 1'b1;
        end else if (i_ctl.cancel_hit) begin
            n_out_vld  = 1'b1;
            n_out_kind = KIND_CANCELLED;
            n_out_id   = r_cid;
            n_out_last = 1'b1;
        end else if (i_ctl.not_found) begin
            n_out_vld  = 1'b1;
            n_out_kind = KIND_NOT_FOUND;
            n_out_id   = r_cid;
            n_out_last = 1'b1;
        end else if (i_ctl.tick_end) begin
            n_out_vld  = 1'b1;
            n_out_kind = r_pend_vld ? KIND_FIRED : KIND_NO_FIRE;
            n_out_id   = r_pend_vld ? r_pend_id : '0;
            n_out_last = 1'b1;
        end else if (report && r_pend_vld) begin
            // a later fire exists, so the pending one is not last
            n_out_vld  = 1'b1;
            n_out_kind = KIND_FIRED;
            n_out_id   = r_pend_id;
            n_out_last = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
        end
        r_out_kind <= n_out_kind;
        r_out_id   <= n_out_id;
        r_out_last <= n_out_last;
    end

    assign o_valid   = r_out_vld;
    assign o_kind    = r_out_kind;
    assign o_task_id = r_out_id;
    assign o_last    = r_out_last;

endmodule

`default_nettype wire

// ===== rtl/core/software_timer_table.sv =====
// ----------------------------------------------------------------------------
// Software timer table
// Table of one-shot and periodic timers driven by add, cancel and tick words.
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low. Results appear
// on o_kind/o_task_id/o_last for one cycle each, marked by o_valid, and must
// be taken as they come: the receiver cannot stall. Add, cancel and tick
// scan the entry store one slot per cycle, cancel and tick through its single
// read port; a tick visits every slot, while add and cancel stop early when a
// free slot or the matching id is found. An unknown command code is taken and
// gives no result. A tick reports at most 16 fires in slot order, the final
// one marked last.
// ----------------------------------------------------------------------------
`default_nettype none

module software_timer_table #(
    parameter int SLOTS = stt_pkg::SLOTS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic [stt_pkg::CMD_W-1:0]  i_cmd,
    input  wire logic [stt_pkg::MS_W-1:0]   i_interval_ms,
    input  wire logic                       i_one_shot,
    input  wire logic [stt_pkg::ID_W-1:0]   i_cancel_id,
    input  wire logic [stt_pkg::MS_W-1:0]   i_delta_ms,
    input  wire logic [stt_pkg::TAG_W-1:0]  i_frame_tag,
    output logic                            o_valid,
    output logic [stt_pkg::KIND_W-1:0]      o_kind,
    output logic [stt_pkg::ID_W-1:0]        o_task_id,
    output logic                            o_last
);
    import stt_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    t_ctl_cmd         ctl;
    t_ctl_sts         sts;
    logic [IDX_W-1:0] idx;

    // Scan sequencer
    stt_ctrl #(
        .SLOTS (SLOTS),
        .IDX_W (IDX_W)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_cmd   (i_cmd),
        .i_sts   (sts),
        .o_ctl   (ctl),
        .o_idx   (idx)
    );

    // Entry store and result path
    stt_dp #(
        .SLOTS (SLOTS),
        .IDX_W (IDX_W)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl),
        .i_idx         (idx),
        .o_sts         (sts),
        .i_cmd         (i_cmd),
        .i_interval_ms (i_interval_ms),
        .i_one_shot    (i_one_shot),
        .i_cancel_id   (i_cancel_id),
        .i_delta_ms    (i_delta_ms),
        .i_frame_tag   (i_frame_tag),
        .o_valid       (o_valid),
        .o_kind        (o_kind),
        .o_task_id     (o_task_id),
        .o_last        (o_last)
    );

endmodule

`default_nettype wire
